[rtl/core/http_response_length_parser_assert.svh]
// Assertion macros shared by the length parser modules.
// Both macros sample on the rising clock edge and stay quiet while reset is held.
`ifndef HTTP_RESPONSE_LENGTH_PARSER_ASSERT_SVH
`define HTTP_RESPONSE_LENGTH_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The condition implies the consequence in the same cycle.
`define HRLP_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hrlp assertion failed");

// The condition implies the consequence in the next cycle.
`define HRLP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hrlp assertion failed");

`else

`define HRLP_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define HRLP_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/hrlp_pkg.sv]
package hrlp_pkg;

	// Header key and number width
	localparam int PREFIX_LEN  = 16;
	localparam int KEY_IDX_W   = $clog2(PREFIX_LEN);
	localparam int LENGTH_BITS = 32;
	localparam int ACC_W       = LENGTH_BITS + 4;
	localparam int CLEN_W      = 32;
	localparam int COUNT_W     = 31;
	localparam int LINE_POS_W  = 5;

	localparam logic [LINE_POS_W-1:0] LINE_MAX = {LINE_POS_W{1'b1}};
	localparam logic [COUNT_W-1:0]    COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [LENGTH_BITS-1:0] LEN_CAP = {1'b1, {(LENGTH_BITS-1){1'b0}}};

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// "Content-Length: "
	localparam logic [7:0] KEY_TEXT [PREFIX_LEN] = '{
		8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
		8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20
	};

	typedef logic signed [CLEN_W-1:0] clen_t;

	typedef enum logic [1:0] {
		CMD_DATA     = 2'd0,
		CMD_CLOSE    = 2'd1,
		CMD_LINK_ERR = 2'd2,
		CMD_RESTART  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_BODY   = 2'd1,
		PH_DONE   = 2'd2,
		PH_FAIL   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_NONE   = 3'd0,
		ST_DONE   = 3'd1,
		ST_OVER   = 3'd2,
		ST_LINK   = 3'd3,
		ST_CLOSED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		NS_WS     = 2'd0,
		NS_SIGN   = 2'd1,
		NS_DIGITS = 2'd2,
		NS_END    = 2'd3
	} nstage_t;

	typedef struct packed {
		cmd_t       command;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		phase_t             phase;
		status_t            status;
		logic               body_valid;
		logic [7:0]         body_byte;
		clen_t              declared_len;
		logic [COUNT_W-1:0] body_count;
	} result_t;

	// Step control from the top level to the line parser
	typedef struct packed {
		logic       apply;
		logic       restart;
		logic [7:0] data_byte;
	} line_step_t;

	// Events the line parser reports for the current header byte
	typedef struct packed {
		logic  header_end;
		logic  commit;
		clen_t commit_value;
	} line_evt_t;

endpackage

[rtl/core/hrlp_line_parser.sv]
`include "http_response_length_parser_assert.svh"

module hrlp_line_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  hrlp_pkg::line_step_t step,
	output hrlp_pkg::line_evt_t  evt
);
	import hrlp_pkg::*;

	logic [LINE_POS_W-1:0]  line_pos_q;
	logic                   prefix_ok_q;
	logic                   first_is_cr_q;
	nstage_t                ns_q;
	logic                   negative_q;
	logic [LENGTH_BITS-1:0] pending_q;

	logic [7:0]             c;
	logic                   is_nl;
	logic                   is_cr;
	logic                   is_blank;
	logic                   is_digit;
	logic                   is_sign;
	logic                   in_prefix;
	logic                   key_match;
	logic                   feed;
	nstage_t                ns_next;
	logic [ACC_W-1:0]       p_ext;
	logic [ACC_W-1:0]       acc;
	logic [LENGTH_BITS-1:0] acc_sat;
	logic [LENGTH_BITS-1:0] pos_value;
	logic signed [LENGTH_BITS:0] neg_value;

	// Classify the incoming byte
	assign c         = step.data_byte;
	assign is_nl     = (c == CH_NL);
	assign is_cr     = (c == CH_CR);
	assign is_blank  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
	                   (c == CH_FF) || (c == CH_CR);
	assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
	assign is_sign   = (c == CH_PLUS) || (c == CH_MINUS);
	assign in_prefix = (line_pos_q < LINE_POS_W'(PREFIX_LEN));
	assign key_match = (c == KEY_TEXT[line_pos_q[KEY_IDX_W-1:0]]);
	assign feed      = !in_prefix && prefix_ok_q;

	// Number scanner next state
	always_comb begin
		unique case (ns_q)
			NS_WS: begin
				if (is_blank) begin
					ns_next = NS_WS;
				end else if (is_sign) begin
					ns_next = NS_SIGN;
				end else begin
					ns_next = is_digit ? NS_DIGITS : NS_END;
				end
			end
			NS_SIGN, NS_DIGITS: ns_next = is_digit ? NS_DIGITS : NS_END;
			NS_END:             ns_next = NS_END;
		endcase
	end

	// Accumulate one decimal digit, saturating at the cap
	always_comb begin
		p_ext   = ACC_W'(pending_q);
		acc     = (p_ext << 3) + (p_ext << 1) + ACC_W'(c - CH_ZERO);
		acc_sat = (acc > ACC_W'(LEN_CAP)) ? LEN_CAP : acc[LENGTH_BITS-1:0];
	end

	// Signed value to commit at the end of a key line
	always_comb begin
		neg_value = -$signed({1'b0, pending_q});
		pos_value = (pending_q >= LEN_CAP) ? (LEN_CAP - LENGTH_BITS'(1)) : pending_q;
		evt.header_end   = is_nl && (line_pos_q == LINE_POS_W'(1)) && first_is_cr_q;
		evt.commit       = is_nl && !evt.header_end && prefix_ok_q && !in_prefix;
		evt.commit_value = negative_q ? CLEN_W'(neg_value) : CLEN_W'(pos_value);
	end

	// Line state: clear on restart or newline, advance on other header bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_pos_q    <= '0;
			prefix_ok_q   <= 1'b1;
			first_is_cr_q <= 1'b0;
			ns_q          <= NS_WS;
			negative_q    <= 1'b0;
			pending_q     <= '0;
		end else if (step.restart || (step.apply && is_nl)) begin
			line_pos_q    <= '0;
			prefix_ok_q   <= 1'b1;
			first_is_cr_q <= 1'b0;
			ns_q          <= NS_WS;
			negative_q    <= 1'b0;
			pending_q     <= '0;
		end else if (step.apply) begin
			if ((line_pos_q == '0) && is_cr) begin
				first_is_cr_q <= 1'b1;
			end
			if (in_prefix && !key_match) begin
				prefix_ok_q <= 1'b0;
			end
			if (feed) begin
				ns_q <= ns_next;
				if ((ns_q == NS_WS) && is_sign) begin
					negative_q <= (c == CH_MINUS);
				end
				if (ns_next == NS_DIGITS) begin
					pending_q <= acc_sat;
				end
			end
			if (line_pos_q != LINE_MAX) begin
				line_pos_q <= line_pos_q + LINE_POS_W'(1);
			end
		end
	end

	`HRLP_ASSERT_NEXT(a_restart_clears_line, clk, arst_n, step.restart,
		(line_pos_q == '0) && prefix_ok_q && (pending_q == '0))
	`HRLP_ASSERT_IMPLY(a_commit_needs_key, clk, arst_n, evt.commit,
		prefix_ok_q && (line_pos_q >= LINE_POS_W'(PREFIX_LEN)))
	`HRLP_ASSERT_IMPLY(a_pending_capped, clk, arst_n, 1'b1, pending_q <= LEN_CAP)

endmodule

[rtl/core/http_response_length_parser.sv]
// Channel  | Handshake                  | Payload
// ---------+----------------------------+----------------------------------
// item     | item_valid / item_stall    | item: command, data_byte
// result   | result_valid / result_stall| result: phase, status, body byte,
//          |                            |   declared_len, body_count
//
// One request per cycle while item_stall is low; a taken request is held in the input
// register, and the state update then loads its result into the result register, from
// which it can be taken.
// The per-byte header and body update is combinational logic between the two registers.
// Reset returns to the header phase with no length and a zero count.
// A stalled result holds the result register; the input register then fills and
// item_stall rises until the result is taken.
`include "http_response_length_parser_assert.svh"

module http_response_length_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  hrlp_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output hrlp_pkg::result_t result
);
	import hrlp_pkg::*;

	// Pipeline registers
	logic    valid_s1;
	item_t   item_s1;
	result_t result_s2;
	logic    valid_s2;

	// Parser state
	phase_t             phase_q;
	status_t            status_q;
	logic               started_q;
	clen_t              declared_q;
	logic [COUNT_W-1:0] count_q;

	// Next-state values
	phase_t             phase_d;
	status_t            status_d;
	logic               started_d;
	clen_t              declared_d;
	logic [COUNT_W-1:0] count_d;
	logic               body_valid_d;

	logic               advance;
	logic               fire;
	logic               active;
	logic [COUNT_W-1:0] count_inc;
	clen_t              count_ext;
	line_step_t         line_step;
	line_evt_t          line_evt;

	// Handshake: the result register frees when empty or taken
	assign advance    = !valid_s2 || !result_stall;
	assign fire       = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;

	assign active    = (phase_q == PH_HEADER) || (phase_q == PH_BODY);
	assign count_inc = (count_q != COUNT_MAX) ? (count_q + COUNT_W'(1)) : count_q;
	assign count_ext = $signed(CLEN_W'(count_inc));

	always_comb begin
		line_step.apply     = fire && (phase_q == PH_HEADER) && (item_s1.command == CMD_DATA);
		line_step.restart   = fire && (item_s1.command == CMD_RESTART);
		line_step.data_byte = item_s1.data_byte;
	end

	hrlp_line_parser u_line (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (line_step),
		.evt    (line_evt)
	);

	// Phase and status next state
	always_comb begin
		phase_d    = phase_q;
		status_d   = status_q;
		started_d  = started_q;
		declared_d = declared_q;
		count_d    = count_q;
		unique case (item_s1.command)
			CMD_RESTART: begin
				phase_d    = PH_HEADER;
				status_d   = ST_NONE;
				started_d  = 1'b0;
				declared_d = '0;
				count_d    = '0;
			end
			CMD_DATA: begin
				if (active) begin
					started_d = 1'b1;
					if (phase_q == PH_HEADER) begin
						if (line_evt.header_end) begin
							phase_d = PH_BODY;
						end
						if (line_evt.commit) begin
							declared_d = line_evt.commit_value;
						end
					end else begin
						count_d = count_inc;
						if (count_ext == declared_q) begin
							phase_d  = PH_DONE;
							status_d = ST_DONE;
						end else if (count_ext > declared_q) begin
							phase_d  = PH_FAIL;
							status_d = ST_OVER;
						end
					end
				end
			end
			CMD_CLOSE: begin
				if (active) begin
					phase_d  = PH_FAIL;
					status_d = ST_CLOSED;
				end
			end
			CMD_LINK_ERR: begin
				if (active && started_q) begin
					phase_d  = PH_FAIL;
					status_d = ST_LINK;
				end
			end
		endcase
	end

	// Body pass-through flag
	always_comb begin
		body_valid_d = (item_s1.command == CMD_DATA) && (phase_q == PH_BODY);
	end

	// Input register: take a request whenever the stage is free or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// Parser state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			status_q   <= ST_NONE;
			started_q  <= 1'b0;
			declared_q <= '0;
			count_q    <= '0;
		end else if (fire) begin
			phase_q    <= phase_d;
			status_q   <= status_d;
			started_q  <= started_d;
			declared_q <= declared_d;
			count_q    <= count_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (advance) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2.phase        <= phase_d;
			result_s2.status       <= status_d;
			result_s2.body_valid   <= body_valid_d;
			result_s2.body_byte    <= body_valid_d ? item_s1.data_byte : 8'h00;
			result_s2.declared_len <= declared_d;
			result_s2.body_count   <= count_d;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	`HRLP_ASSERT_IMPLY(a_stall_needs_item, clk, arst_n, item_stall, valid_s1 && valid_s2)
	`HRLP_ASSERT_NEXT(a_terminal_holds, clk, arst_n,
		fire && !active && (item_s1.command != CMD_RESTART),
		(phase_q == $past(phase_q)) && (status_q == $past(status_q)))
	`HRLP_ASSERT_NEXT(a_count_monotonic, clk, arst_n,
		fire && (item_s1.command != CMD_RESTART), count_q >= $past(count_q))
	`HRLP_ASSERT_NEXT(a_body_byte_flag, clk, arst_n,
		fire && (phase_q == PH_BODY) && (item_s1.command == CMD_DATA),
		valid_s2 && result_s2.body_valid)

endmodule

[sim/http_response_length_parser_checker.sv]
`timescale 1ns / 100ps

module http_response_length_parser_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_stall,
	input  hrlp_pkg::item_t   item,
	input  logic              result_valid,
	input  logic              result_stall,
	input  hrlp_pkg::result_t result,
	output int                fault_count,
	output int                awaited_count
);
	import hrlp_pkg::*;

	// Magnitude cap of the length accumulator
	localparam logic [39:0] NUM_CAP = 40'd1 << (LENGTH_BITS - 1);

	// Parser state as the block should hold it
	phase_t                  parse_ph;
	logic                    started;
	logic [LINE_POS_W-1:0]   line_pos;
	logic                    prefix_ok;
	logic                    first_cr;
	nstage_t                 num_stage;
	logic                    num_neg;
	logic [39:0]             num_acc;
	clen_t                   declared;
	logic [COUNT_W-1:0]      rx_count;
	status_t                 fin_status;

	result_t                 awaited [$];
	result_t                 predicted;
	result_t                 want;
	int                      result_index;

	initial fault_count = 0;

	task automatic report_fault(input string msg);
		$display("[%0t] result %0d: %s", $realtime, result_index, msg);
		fault_count++;
	endtask

	// Start a fresh header line
	task automatic new_line();
		line_pos  = '0;
		prefix_ok = 1'b1;
		first_cr  = 1'b0;
		num_stage = NS_WS;
		num_neg   = 1'b0;
		num_acc   = '0;
	endtask

	task automatic clear_parser();
		parse_ph   = PH_HEADER;
		started    = 1'b0;
		declared   = '0;
		rx_count   = '0;
		fin_status = ST_NONE;
		new_line();
	endtask

	// Advance the parser by one request and build the result it reports
	task automatic track_response(input item_t req, output result_t res);
		logic [7:0] c;
		logic       active;
		logic       digit;
		logic       blank;
		logic       delivered;
		c         = req.data_byte;
		active    = parse_ph == PH_HEADER || parse_ph == PH_BODY;
		digit     = c >= CH_ZERO && c <= CH_NINE;
		blank     = c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
		delivered = 1'b0;

		if (req.command == CMD_RESTART) begin
			clear_parser();
		end else if (active && req.command == CMD_DATA) begin
			started = 1'b1;
			if (parse_ph == PH_HEADER) begin
				if (c == CH_NL) begin
					// a lone CR line ends the header, a full key line commits its value
					if (line_pos == 1 && first_cr) begin
						parse_ph = PH_BODY;
					end else if (prefix_ok && line_pos >= PREFIX_LEN) begin
						if (num_neg)
							declared = clen_t'(40'd0 - num_acc);
						else
							declared = clen_t'((num_acc < NUM_CAP) ? num_acc : NUM_CAP - 40'd1);
					end
					new_line();
				end else begin
					if (line_pos == 0 && c == CH_CR)
						first_cr = 1'b1;
					if (line_pos < PREFIX_LEN) begin
						if (c != KEY_TEXT[line_pos])
							prefix_ok = 1'b0;
					end else if (prefix_ok) begin
						// skip blanks, take one sign, then gather digits
						if (num_stage == NS_WS) begin
							if (c == CH_PLUS || c == CH_MINUS) begin
								num_neg   = c == CH_MINUS;
								num_stage = NS_SIGN;
							end else if (!blank) begin
								num_stage = digit ? NS_DIGITS : NS_END;
							end
						end else if (num_stage != NS_END) begin
							num_stage = digit ? NS_DIGITS : NS_END;
						end
						if (num_stage == NS_DIGITS) begin
							num_acc = num_acc * 10 + (c - CH_ZERO);
							if (num_acc > NUM_CAP)
								num_acc = NUM_CAP;
						end
					end
					if (line_pos < LINE_MAX)
						line_pos++;
				end
			end else begin
				// body byte: count it and check against the declared length
				delivered = 1'b1;
				if (rx_count < COUNT_MAX)
					rx_count++;
				if (longint'(rx_count) == longint'(declared)) begin
					parse_ph   = PH_DONE;
					fin_status = ST_DONE;
				end else if (longint'(rx_count) > longint'(declared)) begin
					parse_ph   = PH_FAIL;
					fin_status = ST_OVER;
				end
			end
		end else if (active && req.command == CMD_CLOSE) begin
			parse_ph   = PH_FAIL;
			fin_status = ST_CLOSED;
		end else if (active && req.command == CMD_LINK_ERR && started) begin
			parse_ph   = PH_FAIL;
			fin_status = ST_LINK;
		end

		res.phase        = parse_ph;
		res.status       = fin_status;
		res.body_valid   = delivered;
		res.body_byte    = delivered ? c : 8'h00;
		res.declared_len = declared;
		res.body_count   = rx_count;
	endtask

	// Predict on every taken request, compare every taken result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			awaited.delete();
			result_index  = 0;
			awaited_count <= 0;
		end else begin
			if (item_valid && !item_stall) begin
				track_response(item, predicted);
				awaited.push_back(predicted);
			end
			if (result_valid && !result_stall) begin
				if (awaited.size() == 0) begin
					report_fault("result arrived with nothing awaited");
				end else begin
					want = awaited.pop_front();
					if (result.phase !== want.phase)
						report_fault($sformatf("phase got %0d, want %0d",
							result.phase, want.phase));
					if (result.status !== want.status)
						report_fault($sformatf("status got %0d, want %0d",
							result.status, want.status));
					if (result.body_valid !== want.body_valid)
						report_fault($sformatf("body_valid got %0b, want %0b",
							result.body_valid, want.body_valid));
					if (result.body_byte !== want.body_byte)
						report_fault($sformatf("body_byte got %02h, want %02h",
							result.body_byte, want.body_byte));
					if (result.declared_len !== want.declared_len)
						report_fault($sformatf("declared_len got %0d, want %0d",
							result.declared_len, want.declared_len));
					if (result.body_count !== want.body_count)
						report_fault($sformatf("body_count got %0d, want %0d",
							result.body_count, want.body_count));
				end
				result_index++;
			end
			awaited_count <= awaited.size();
		end
	end

endmodule

[sim/http_response_length_parser_test.sv]
`timescale 1ns / 100ps

module http_response_length_parser_test;
	import hrlp_pkg::*;

	localparam int ITEM_TARGET = 550;

	logic    clk;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	int      fault_count;
	int      awaited_count;
	int      send_idle_pct;
	int      stall_pct;
	int      sent;

	http_response_length_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	http_response_length_parser_checker response_watch (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.item          (item),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result),
		.fault_count   (fault_count),
		.awaited_count (awaited_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hold back results at random
	always @(posedge clk) begin
		result_stall <= $urandom_range(0, 99) < stall_pct;
	end

	// Offer one request after an optional gap and wait until it is taken
	task automatic send_request(input cmd_t cmd, input logic [7:0] data);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= '{command: cmd, data_byte: data};
		do @(posedge clk); while (item_stall);
		sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_request(CMD_DATA, s[i]);
	endtask

	// End a header line, mostly with CR LF, sometimes with a bare LF
	task automatic send_eol();
		if ($urandom_range(0, 7) != 0)
			send_request(CMD_DATA, CH_CR);
		send_request(CMD_DATA, CH_NL);
	endtask

	// Hold the request side until every result has come back
	task automatic wait_drained();
		item_valid <= 1'b0;
		do @(posedge clk); while (awaited_count != 0);
	endtask

	initial begin
		int body_target;
		int body_n;
		sent          = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_idle_pct = 32;
					stall_pct     = 88;
				end
				1: begin
					send_idle_pct = 88;
					stall_pct     = 32;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
			endcase

			if (p == 0) begin
				// link error before any byte is ignored, after one it fails
				send_request(CMD_LINK_ERR, 8'hFF);
				send_request(CMD_DATA, 8'h00);
				send_request(CMD_LINK_ERR, 8'h00);
				// terminal phase holds against data, close and link error
				send_request(CMD_DATA, 8'hFF);
				send_request(CMD_CLOSE, 8'h5A);
				send_request(CMD_LINK_ERR, 8'hA5);
				send_request(CMD_RESTART, 8'hA5);
				send_request(CMD_CLOSE, 8'h00);
				send_request(CMD_RESTART, 8'h00);
				// header ends at once with no length: first body byte is oversize
				send_request(CMD_DATA, CH_CR);
				send_request(CMD_DATA, CH_NL);
				send_request(CMD_DATA, 8'hA5);
				send_request(CMD_RESTART, 8'hFF);
				// close in the body phase
				send_request(CMD_DATA, CH_CR);
				send_request(CMD_DATA, CH_NL);
				send_request(CMD_CLOSE, 8'hFF);
				send_request(CMD_RESTART, 8'h00);
			end

			while (sent < (p + 1) * ITEM_TARGET / 3) begin
				if ($urandom_range(0, 3) == 0) begin
					// noise: any command, any byte
					repeat ($urandom_range(4, 16))
						send_request(cmd_t'($urandom_range(0, 3)), 8'($urandom));
				end else begin
					send_request(CMD_RESTART, 8'($urandom));

					// unrelated, near-miss and short lines
					repeat ($urandom_range(0, 2)) begin
						case ($urandom_range(0, 5))
							0: send_text("Host: a");
							1: send_text("content-length: 3");
							2: send_text("Content-Length:5");
							3: send_text("Content-Len");
							4: send_text("Content-Length: ");
							default: begin
								send_request(CMD_DATA, CH_CR);
								send_text("X");
							end
						endcase
						send_eol();
					end

					// length lines, plain or with blanks, sign, extremes and trailing junk
					body_target = 0;
					repeat ($urandom_range(0, 2)) begin
						if ($urandom_range(0, 1) == 0) begin
							body_target = $urandom_range(0, 9);
							send_text($sformatf("Content-Length: %0d", body_target));
						end else begin
							body_target = $urandom_range(0, 10);
							send_text("Content-Length: ");
							repeat ($urandom_range(0, 3)) begin
								case ($urandom_range(0, 4))
									0: send_request(CMD_DATA, CH_SPACE);
									1: send_request(CMD_DATA, CH_TAB);
									2: send_request(CMD_DATA, CH_VT);
									3: send_request(CMD_DATA, CH_FF);
									default: send_request(CMD_DATA, CH_CR);
								endcase
							end
							case ($urandom_range(0, 3))
								1: send_text("+");
								2: send_text("-");
								default: ;
							endcase
							case ($urandom_range(0, 6))
								0: send_text("2147483647");
								1: send_text("2147483648");
								2: send_text("4294967296");
								3: send_text("99999999999999999999");
								default: send_text($sformatf("%0d", body_target));
							endcase
							case ($urandom_range(0, 3))
								0: send_text("x7");
								1: send_text(" 12");
								default: ;
							endcase
						end
						send_eol();
					end

					// header end, then the body, sometimes short, long or cut off
					send_request(CMD_DATA, CH_CR);
					send_request(CMD_DATA, CH_NL);
					body_n = body_target + ($urandom_range(0, 3) == 0);
					if ($urandom_range(0, 4) == 0)
						body_n = $urandom_range(0, body_n);
					repeat (body_n)
						send_request(CMD_DATA, 8'($urandom));
					case ($urandom_range(0, 7))
						0: send_request(CMD_CLOSE, 8'($urandom));
						1: send_request(CMD_LINK_ERR, 8'($urandom));
						2: send_request(CMD_DATA, 8'($urandom));
						default: ;
					endcase
				end
			end

			if (p == 0)
				wait_drained();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Stop a hung run
	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

endmodule
